>>> sv/sync_length_sum_frame_receiver_unit_macros.svh
// ---------------------------------------------------------------------------
// sync_length_sum_frame_receiver_unit_macros.svh
// assertion macros shared by the frame receiver modules
// ---------------------------------------------------------------------------
`ifndef SYNC_LENGTH_SUM_FRAME_RECEIVER_UNIT_MACROS_SVH
`define SYNC_LENGTH_SUM_FRAME_RECEIVER_UNIT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define SLSF_CHECK(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("slsf check failed");

// consequence that must hold in the cycle after the antecedent
`define SLSF_CHECK_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slsf sequence check failed");

`endif

>>> sv/slsf_pkg.sv
// ---------------------------------------------------------------------------
// slsf_pkg
// types and codes shared by the frame receiver modules
// ---------------------------------------------------------------------------
package slsf_pkg;

    // shared arithmetic unit operations
    typedef logic alu_op_t;
    localparam alu_op_t ALU_ADD = 1'b0;
    localparam alu_op_t ALU_SUB = 1'b1;

    typedef struct packed {
        logic [7:0] res;
        logic       zero;
        logic       borrow;
    } alu_res_t;

    // parse phases
    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_SYNC2 = 3'd1;
    localparam logic [2:0] PH_ID    = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_SUM   = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_SYNC_FIRST   = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND  = 2'd1;
    localparam logic [1:0] REG_LENGTH_LIMIT = 2'd2;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [5:0] length_limit;
    } cfg_t;

    typedef struct packed {
        logic       en;
        logic [7:0] data;
    } store_wr_t;

    typedef struct packed {
        logic       start;
        logic [7:0] id;
        logic [5:0] length;
    } emit_req_t;

endpackage

>>> sv/slsf_alu.sv
// ---------------------------------------------------------------------------
// slsf_alu
// shared 8-bit add / subtract unit with zero and borrow flags
// ---------------------------------------------------------------------------
module slsf_alu
    import slsf_pkg::*;
(
    input  alu_op_t    op,
    input  logic [7:0] a,
    input  logic [7:0] b,
    output alu_res_t   result
);

    logic [8:0] wide;

    always_comb
    begin
        case (op)
            ALU_ADD: wide = {1'b0, a} + {1'b0, b};
            ALU_SUB: wide = {1'b0, a} - {1'b0, b};
            default: wide = {1'b0, a};
        endcase
        result.res    = wide[7:0];
        result.zero   = (wide[7:0] == 8'd0);
        // for a subtract, set when a < b
        result.borrow = wide[8];
    end

endmodule

>>> sv/slsf_emit.sv
// ---------------------------------------------------------------------------
// slsf_emit
// payload store and result sequencer with a registered output stage
// ---------------------------------------------------------------------------
`include "sync_length_sum_frame_receiver_unit_macros.svh"

module slsf_emit
    import slsf_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32,
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  store_wr_t             wr,
    input  logic [AW-1:0]         wr_addr,
    input  emit_req_t             req,
    output logic                  idle,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            message_id,
    output logic [5:0]            payload_length,
    output logic [4:0]            byte_index,
    output logic [7:0]            payload_byte,
    output logic                  has_data,
    output logic                  last
);

    localparam logic [1:0] E_IDLE = 2'd0;
    localparam logic [1:0] E_RD   = 2'd1;
    localparam logic [1:0] E_LD   = 2'd2;

    logic [7:0] mem [MAX_PAYLOAD];

    logic [1:0] state_reg, state_next;
    logic [7:0] id_reg, id_next;
    logic [5:0] len_reg, len_next;
    logic [5:0] k_reg, k_next;
    logic [7:0] rd_data_reg;
    logic       valid_reg, valid_next;
    logic [5:0] k_inc;
    logic       is_last;
    logic       load;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
        rd_data_reg <= mem[k_reg[AW-1:0]];
    end

    assign k_inc   = k_reg + 6'd1;
    assign is_last = (len_reg == 6'd0) || (k_inc == len_reg);
    assign load    = (state_reg == E_LD) && (!valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        k_next     = k_reg;
        valid_next = valid_reg;
        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end
        case (state_reg)
            E_IDLE:
            begin
                if (req.start)
                begin
                    id_next    = req.id;
                    len_next   = req.length;
                    k_next     = 6'd0;
                    state_next = E_RD;
                end
            end
            E_RD:
            begin
                state_next = E_LD;
            end
            E_LD:
            begin
                if (load)
                begin
                    valid_next = 1'b1;
                    if (is_last)
                    begin
                        state_next = E_IDLE;
                    end
                    else
                    begin
                        k_next     = k_inc;
                        state_next = E_RD;
                    end
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            valid_reg <= 1'b0;
            id_reg    <= 8'd0;
            len_reg   <= 6'd0;
            k_reg     <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            k_reg     <= k_next;
        end
    end

    // output word register, payload only
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            message_id     <= id_reg;
            payload_length <= len_reg;
            byte_index     <= k_reg[4:0];
            payload_byte   <= (len_reg == 6'd0) ? 8'd0 : rd_data_reg;
            has_data       <= (len_reg != 6'd0);
            last           <= is_last;
        end
    end

    assign idle      = (state_reg == E_IDLE);
    assign out_valid = valid_reg;

    `SLSF_CHECK(a_start_only_idle, !(req.start && (state_reg != E_IDLE)))
    `SLSF_CHECK_NEXT(a_last_to_idle, load && is_last, state_reg == E_IDLE && valid_reg)
    `SLSF_CHECK_NEXT(a_out_held, valid_reg && !out_ready, valid_reg)

endmodule

>>> sv/slsf_parser.sv
// ---------------------------------------------------------------------------
// slsf_parser
// byte sequencer: drives the shared unit through the steps of each byte
// ---------------------------------------------------------------------------
`include "sync_length_sum_frame_receiver_unit_macros.svh"

module slsf_parser
    import slsf_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32,
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          opcode,
    input  logic [7:0]    rx_byte,
    output store_wr_t     wr,
    output logic [AW-1:0] wr_addr,
    output emit_req_t     req,
    input  logic          emit_idle
);

    localparam logic [7:0] MAX_W = 8'(MAX_PAYLOAD);

    localparam logic [2:0] P_READY = 3'd0;
    localparam logic [2:0] P_A     = 3'd1;
    localparam logic [2:0] P_B     = 3'd2;
    localparam logic [2:0] P_C     = 3'd3;
    localparam logic [2:0] P_EMIT  = 3'd4;
    localparam logic [2:0] P_DRAIN = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [7:0] byte_reg, byte_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] id_reg, id_next;
    logic [5:0] len_reg, len_next;
    logic [5:0] fill_reg, fill_next;

    alu_op_t    alu_op;
    logic [7:0] alu_a;
    logic [7:0] alu_b;
    alu_res_t   alu_out;
    logic [7:0] limit;

    slsf_alu u_alu
    (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_out)
    );

    assign limit = ({2'b00, cfg.length_limit} > MAX_W) ? MAX_W : {2'b00, cfg.length_limit};

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        byte_next  = byte_reg;
        sum_next   = sum_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        fill_next  = fill_reg;
        alu_op     = ALU_ADD;
        alu_a      = 8'd0;
        alu_b      = byte_reg;
        wr.en      = 1'b0;
        wr.data    = byte_reg;
        req.start  = 1'b0;
        req.id     = id_reg;
        req.length = len_reg;
        case (state_reg)
            P_READY:
            begin
                if (in_valid)
                begin
                    if (opcode)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        byte_next  = rx_byte;
                        state_next = P_A;
                    end
                end
            end
            P_A:
            begin
                case (phase_reg)
                    PH_SYNC2:
                    begin
                        alu_a      = sum_reg;
                        sum_next   = alu_out.res;
                        state_next = P_B;
                    end
                    PH_ID:
                    begin
                        alu_a      = sum_reg;
                        sum_next   = alu_out.res;
                        id_next    = byte_reg;
                        phase_next = PH_LEN;
                        state_next = P_READY;
                    end
                    PH_LEN:
                    begin
                        alu_op = ALU_SUB;
                        alu_a  = limit;
                        if (alu_out.borrow)
                        begin
                            phase_next = PH_HUNT;
                            state_next = P_READY;
                        end
                        else
                        begin
                            state_next = P_B;
                        end
                    end
                    PH_DATA:
                    begin
                        alu_a      = sum_reg;
                        sum_next   = alu_out.res;
                        wr.en      = ({2'b00, fill_reg} < MAX_W);
                        state_next = P_B;
                    end
                    PH_SUM:
                    begin
                        alu_op     = ALU_SUB;
                        alu_a      = sum_reg;
                        phase_next = PH_HUNT;
                        state_next = alu_out.zero ? P_EMIT : P_READY;
                    end
                    default:
                    begin
                        // hunting: sum restarts from this byte
                        sum_next   = alu_out.res;
                        state_next = P_B;
                    end
                endcase
            end
            P_B:
            begin
                state_next = P_READY;
                case (phase_reg)
                    PH_SYNC2:
                    begin
                        alu_op     = ALU_SUB;
                        alu_a      = byte_reg;
                        alu_b      = cfg.sync_second;
                        phase_next = alu_out.zero ? PH_ID : PH_HUNT;
                    end
                    PH_LEN:
                    begin
                        alu_a      = sum_reg;
                        sum_next   = alu_out.res;
                        len_next   = byte_reg[5:0];
                        fill_next  = 6'd0;
                        phase_next = (byte_reg != 8'd0) ? PH_DATA : PH_SUM;
                    end
                    PH_DATA:
                    begin
                        alu_a      = {2'b00, fill_reg};
                        alu_b      = 8'd1;
                        fill_next  = alu_out.res[5:0];
                        state_next = P_C;
                    end
                    default:
                    begin
                        alu_op     = ALU_SUB;
                        alu_a      = byte_reg;
                        alu_b      = cfg.sync_first;
                        phase_next = alu_out.zero ? PH_SYNC2 : PH_HUNT;
                    end
                endcase
            end
            P_C:
            begin
                // payload complete once fill reaches the length
                alu_op     = ALU_SUB;
                alu_a      = {2'b00, fill_reg};
                alu_b      = {2'b00, len_reg};
                state_next = P_READY;
                if (!alu_out.borrow)
                begin
                    phase_next = PH_SUM;
                end
            end
            P_EMIT:
            begin
                req.start  = 1'b1;
                state_next = P_DRAIN;
            end
            P_DRAIN:
            begin
                if (emit_idle)
                begin
                    state_next = P_READY;
                end
            end
            default:
            begin
                state_next = P_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_READY;
            phase_reg <= PH_HUNT;
            sum_reg   <= 8'd0;
            id_reg    <= 8'd0;
            len_reg   <= 6'd0;
            fill_reg  <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign in_ready = (state_reg == P_READY);
    assign wr_addr  = fill_reg[AW-1:0];

    `SLSF_CHECK(a_wr_in_data, !wr.en || (phase_reg == PH_DATA && state_reg == P_A))
    `SLSF_CHECK_NEXT(a_start_takes, req.start, !emit_idle && state_reg == P_DRAIN)
    `SLSF_CHECK(a_phase_known, phase_reg <= PH_SUM)

endmodule

>>> sv/sync_length_sum_frame_receiver_unit.sv
// ---------------------------------------------------------------------------
// sync_length_sum_frame_receiver_unit
// two-sync-byte, length-prefixed frame receiver with additive checksum
// ---------------------------------------------------------------------------
// Each word in carries one received byte or a timeout. A small sequencer runs
// every byte through one shared 8-bit add/subtract unit: a timeout skips it;
// an id byte is added to the sum, a checksum byte compared to it, a length
// checked against the limit and added if accepted, a sync byte added and
// compared, a payload byte added and stored, then the fill count stepped and
// compared to the length. After a good checksum the frame is read from the
// payload store entry by entry, store read then output register load, held by
// any output stall; input is held off until the cycle after the last word of
// the frame is in the output register. Empty frames give one word with has_data
// low. Bad frames give nothing. The store needs no clearing after reset.
module sync_length_sum_frame_receiver_unit
    import slsf_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       opcode,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] message_id,
    output logic [5:0] payload_length,
    output logic [4:0] byte_index,
    output logic [7:0] payload_byte,
    output logic       has_data,
    output logic       last
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    cfg_t          cfg_reg;
    store_wr_t     wr;
    logic [AW-1:0] wr_addr;
    emit_req_t     req;
    logic          emit_idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first   <= 8'd170;
            cfg_reg.sync_second  <= 8'd175;
            cfg_reg.length_limit <= 6'd32;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SYNC_FIRST:   cfg_reg.sync_first   <= cfg_data;
                REG_SYNC_SECOND:  cfg_reg.sync_second  <= cfg_data;
                REG_LENGTH_LIMIT: cfg_reg.length_limit <= cfg_data[5:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    slsf_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .rx_byte   (rx_byte),
        .wr        (wr),
        .wr_addr   (wr_addr),
        .req       (req),
        .emit_idle (emit_idle)
    );

    slsf_emit #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_emit
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr             (wr),
        .wr_addr        (wr_addr),
        .req            (req),
        .idle           (emit_idle),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .message_id     (message_id),
        .payload_length (payload_length),
        .byte_index     (byte_index),
        .payload_byte   (payload_byte),
        .has_data       (has_data),
        .last           (last)
    );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the two-sync-byte frame receiver
// ---------------------------------------------------------------------------
// Received bytes and timeouts are queued by the stimulus process and fed to
// the block in bursts with random gaps. Every accepted word runs through a
// shadow frame parser that queues the payload words the block owes. The
// output side stalls in changing patterns and checks each word against the
// oldest one owed. Phases cover reset settings, a zero length limit, a full
// 32-byte limit and a random setting, with writes only while the block idles.
module tb_top
    import slsf_pkg::*;
();

    localparam int FRAME_MAX = 32;
    localparam int SETTLE_CYCLES = 24;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    // index with no register behind it
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int READY_ALWAYS = 0;
    localparam int READY_COIN   = 1;
    localparam int READY_SPARSE = 2;
    localparam int READY_PERIOD = 3;

    typedef struct packed {
        logic       op;
        logic [7:0] b;
    } rx_word_t;

    typedef struct packed {
        logic [7:0] id;
        logic [5:0] len;
        logic [4:0] idx;
        logic [7:0] data;
        logic       has;
        logic       last;
    } frame_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = 2'd0;
    logic [7:0] cfg_data = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       opcode = 1'b0;
    logic [7:0] rx_byte = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] message_id;
    logic [5:0] payload_length;
    logic [4:0] byte_index;
    logic [7:0] payload_byte;
    logic       has_data;
    logic       last;

    // settings as the block holds them
    logic [7:0] cfg_sync1 = 8'hAA;
    logic [7:0] cfg_sync2 = 8'hAF;
    logic [5:0] cfg_limit = 6'd32;

    // shadow parser state
    logic [2:0] sh_phase = PH_HUNT;
    logic [7:0] sh_sum = 8'd0;
    logic [7:0] sh_id = 8'd0;
    logic [5:0] sh_len = 6'd0;
    logic [5:0] sh_fill = 6'd0;
    logic [7:0] sh_store [FRAME_MAX];

    rx_word_t    rx_words_pending [$];
    frame_word_t frame_words_owed [$];
    int          words_queued = 0;
    int          mismatch_count = 0;

    rx_word_t    next_rx;
    frame_word_t got_word;
    frame_word_t owed_word;
    int          burst_left;
    int          gap_left;
    int          stall_mode;
    int          mode_left;
    int          gap_pick;

    sync_length_sum_frame_receiver_unit #(
        .MAX_PAYLOAD(FRAME_MAX)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .message_id     (message_id),
        .payload_length (payload_length),
        .byte_index     (byte_index),
        .payload_byte   (payload_byte),
        .has_data       (has_data),
        .last           (last)
    );

    always #4 clk = ~clk;

    // queue the words a good frame hands out
    task automatic emit_owed();
        frame_word_t w;
        int i;
        w.id = sh_id;
        w.len = sh_len;
        if (sh_len == 6'd0)
        begin
            w.idx = 5'd0;
            w.data = 8'd0;
            w.has = 1'b0;
            w.last = 1'b1;
            frame_words_owed.push_back(w);
        end
        else
        begin
            for (i = 0; i < sh_len && i < FRAME_MAX; i++)
            begin
                w.idx = i[4:0];
                w.data = sh_store[i];
                w.has = 1'b1;
                w.last = (i + 1 == sh_len);
                frame_words_owed.push_back(w);
            end
        end
    endtask

    task automatic track_rx_word(input logic op, input logic [7:0] b);
        logic [5:0] lim;
        if (op == OP_TIMEOUT)
        begin
            sh_phase = PH_HUNT;
        end
        else
        begin
            case (sh_phase)
                PH_SYNC2:
                begin
                    sh_sum = sh_sum + b;
                    sh_phase = (b == cfg_sync2) ? PH_ID : PH_HUNT;
                end
                PH_ID:
                begin
                    sh_id = b;
                    sh_sum = sh_sum + b;
                    sh_phase = PH_LEN;
                end
                PH_LEN:
                begin
                    lim = (cfg_limit > FRAME_MAX) ? 6'(FRAME_MAX) : cfg_limit;
                    if (b <= lim)
                    begin
                        sh_len = b[5:0];
                        sh_fill = 6'd0;
                        sh_sum = sh_sum + b;
                        sh_phase = (b != 8'd0) ? PH_DATA : PH_SUM;
                    end
                    else
                    begin
                        sh_phase = PH_HUNT;
                    end
                end
                PH_DATA:
                begin
                    if (sh_fill < FRAME_MAX)
                        sh_store[sh_fill] = b;
                    sh_fill = sh_fill + 6'd1;
                    sh_sum = sh_sum + b;
                    if (sh_fill >= sh_len)
                        sh_phase = PH_SUM;
                end
                PH_SUM:
                begin
                    if (sh_sum == b)
                        emit_owed();
                    sh_phase = PH_HUNT;
                end
                default:
                begin
                    // any byte while hunting seeds the sum
                    sh_sum = b;
                    sh_phase = (b == cfg_sync1) ? PH_SYNC2 : PH_HUNT;
                end
            endcase
        end
    endtask

    // sender: bursts of words with random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                track_rx_word(opcode, rx_byte);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (rx_words_pending.size() > 0)
                begin
                    next_rx = rx_words_pending.pop_front();
                    in_valid <= 1'b1;
                    opcode <= next_rx.op;
                    rx_byte <= next_rx.b;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_pick = $urandom_range(0, 9);
                        if (gap_pick < 4)
                            gap_left = 0;
                        else if (gap_pick < 7)
                            gap_left = $urandom_range(1, 3);
                        else
                            gap_left = $urandom_range(4, 12);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each word it takes, under a stall pattern picked anew at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_mode = READY_ALWAYS;
            mode_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_word = '{message_id, payload_length, byte_index, payload_byte,
                             has_data, last};
                if (frame_words_owed.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: expected none, actual %h/%0d/%0d/%h/%b/%b",
                             $time, got_word.id, got_word.len, got_word.idx,
                             got_word.data, got_word.has, got_word.last);
                end
                else
                begin
                    owed_word = frame_words_owed.pop_front();
                    if (got_word !== owed_word)
                    begin
                        mismatch_count++;
                        $display("%0t: expected %h/%0d/%0d/%h/%b/%b, actual %h/%0d/%0d/%h/%b/%b",
                                 $time, owed_word.id, owed_word.len, owed_word.idx,
                                 owed_word.data, owed_word.has, owed_word.last,
                                 got_word.id, got_word.len, got_word.idx,
                                 got_word.data, got_word.has, got_word.last);
                    end
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(READY_ALWAYS, READY_PERIOD);
                mode_left = $urandom_range(8, 80);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                READY_ALWAYS: out_ready <= 1'b1;
                READY_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
                READY_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
                default:      out_ready <= ((mode_left % 8) < 3);
            endcase
        end
    end

    task automatic push_word(input logic op, input logic [7:0] b);
        rx_word_t w;
        w.op = op;
        w.b = b;
        rx_words_pending.push_back(w);
        words_queued++;
    endtask

    // one frame with the current sync bytes; cut >= 0 replaces the word at
    // that position and everything after it by a timeout
    task automatic queue_frame(input logic [7:0] id, input int len, input bit alt_fill,
                               input bit bad_sum, input int cut);
        rx_word_t seq [$];
        rx_word_t w;
        logic [7:0] s;
        logic [7:0] d;
        int i;
        w.op = OP_BYTE;
        w.b = cfg_sync1;
        seq.push_back(w);
        w.b = cfg_sync2;
        seq.push_back(w);
        w.b = id;
        seq.push_back(w);
        w.b = 8'(len);
        seq.push_back(w);
        s = cfg_sync1 + cfg_sync2 + id + 8'(len);
        for (i = 0; i < len; i++)
        begin
            d = alt_fill ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
            w.b = d;
            seq.push_back(w);
            s = s + d;
        end
        if (bad_sum)
            s = s + 8'($urandom_range(1, 255));
        w.b = s;
        seq.push_back(w);
        for (i = 0; i < seq.size(); i++)
        begin
            if (cut >= 0 && i == cut)
            begin
                push_word(OP_TIMEOUT, 8'($urandom_range(0, 255)));
                break;
            end
            push_word(seq[i].op, seq[i].b);
        end
    endtask

    // mostly well-formed frames, the rest broken frames and noise
    task automatic run_mix(input int n);
        int stop;
        int r;
        int lim;
        int len;
        logic [7:0] b;
        lim = (cfg_limit > FRAME_MAX) ? FRAME_MAX : int'(cfg_limit);
        stop = words_queued + n;
        while (words_queued < stop)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(0, lim);
            else
                len = $urandom_range(0, (lim < 4) ? lim : 4);
            if (r < 60)
                queue_frame(8'($urandom_range(0, 255)), len, 1'b0, 1'b0, -1);
            else if (r < 70)
                queue_frame(8'($urandom_range(0, 255)), len, 1'b0, 1'b1, -1);
            else if (r < 78)
                queue_frame(8'($urandom_range(0, 255)), len, 1'b0, 1'b0,
                            $urandom_range(0, len + 4));
            else if (r < 85)
            begin
                push_word(OP_BYTE, cfg_sync1);
                push_word(OP_BYTE, cfg_sync2);
                push_word(OP_BYTE, 8'($urandom_range(0, 255)));
                push_word(OP_BYTE, 8'($urandom_range(lim + 1, 255)));
            end
            else if (r < 90)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == cfg_sync2)
                    b = ~b;
                push_word(OP_BYTE, cfg_sync1);
                push_word(OP_BYTE, b);
            end
            else if (r < 96)
                push_word(OP_BYTE, 8'($urandom_range(0, 255)));
            else
                push_word(OP_TIMEOUT, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SYNC_FIRST:   cfg_sync1 = val;
            REG_SYNC_SECOND:  cfg_sync2 = val;
            REG_LENGTH_LIMIT: cfg_limit = val[5:0];
            default:          ;
        endcase
    endtask

    // sender drained, nothing owed, then let trailing words finish;
    // sampled away from the active edge so the sender has settled
    task automatic wait_idle();
        @(negedge clk);
        while (rx_words_pending.size() != 0 || in_valid || frame_words_owed.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: empty frame, sync mismatch on a first-sync value,
        // timeout inside the payload, oversize length, bad sum, extreme bytes
        queue_frame(8'h00, 0, 1'b0, 1'b0, -1);
        push_word(OP_BYTE, cfg_sync1);
        push_word(OP_BYTE, cfg_sync1);
        push_word(OP_BYTE, cfg_sync2);
        queue_frame(8'h11, 3, 1'b0, 1'b0, 5);
        push_word(OP_BYTE, cfg_sync1);
        push_word(OP_BYTE, cfg_sync2);
        push_word(OP_BYTE, 8'h01);
        push_word(OP_BYTE, 8'd33);
        queue_frame(8'h7E, 0, 1'b0, 1'b1, -1);
        queue_frame(8'hFF, 2, 1'b1, 1'b0, -1);
        run_mix(25);
        wait_idle();

        // zero limit: only empty frames get through
        write_reg(REG_SYNC_FIRST, 8'h00);
        write_reg(REG_SYNC_SECOND, 8'hFF);
        write_reg(REG_LENGTH_LIMIT, 8'd0);
        write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
        run_mix(25);
        wait_idle();

        // full limit with two maximum frames
        write_reg(REG_SYNC_FIRST, 8'hFF);
        write_reg(REG_SYNC_SECOND, 8'h00);
        write_reg(REG_LENGTH_LIMIT, 8'd32);
        queue_frame(8'h3C, 32, 1'b0, 1'b0, -1);
        queue_frame(8'hC3, 32, 1'b1, 1'b0, -1);
        run_mix(25);
        wait_idle();

        write_reg(REG_SYNC_FIRST, 8'($urandom_range(0, 255)));
        write_reg(REG_SYNC_SECOND, 8'($urandom_range(0, 255)));
        write_reg(REG_LENGTH_LIMIT, 8'($urandom_range(1, 31)));
        run_mix(30);
        wait_idle();

        if (mismatch_count == 0 && frame_words_owed.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
